/* rtl/smf_track_event_parser_macros.svh */
// Assertion helpers for the parser's top-level RTL.
`ifndef SMF_TRACK_EVENT_PARSER_MACROS_SVH
`define SMF_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smf parser check failed");

// Next-cycle implication.
`define SMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smf parser check failed");

`endif

/* rtl/smf_pkg.sv */
package smf_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_DATA_W  = 48;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_Q = 2'd1;
    localparam logic [1:0] CFG_TEMPO_SCALE = 2'd2;
    localparam logic [1:0] CFG_START_SMP   = 2'd3;

    // Input kinds carried on tuser.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Result event types.
    localparam logic [2:0] EV_NOTE_OFF = 3'd0;
    localparam logic [2:0] EV_NOTE_ON  = 3'd1;
    localparam logic [2:0] EV_CONTROL  = 3'd2;
    localparam logic [2:0] EV_PROGRAM  = 3'd3;
    localparam logic [2:0] EV_BEND     = 3'd4;
    localparam logic [2:0] EV_ALL_OFF  = 3'd5;

    // Stream byte values.
    localparam logic [7:0] B_META       = 8'hFF;
    localparam logic [7:0] B_SYSEX      = 8'hF0;
    localparam logic [7:0] B_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] B_META_TEMPO = 8'h51;
    localparam logic [7:0] B_META_EOT   = 8'h2F;
    localparam logic [7:0] B_CC_ALL_OFF = 8'h7B;
    localparam logic [7:0] B_CC_RESET   = 8'h78;
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_POLY_AT   = 4'hA;
    localparam logic [3:0] HI_CONTROL   = 4'hB;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_BEND      = 4'hE;

    localparam logic [17:0] RATE_RESET  = 18'd48000;
    localparam logic [14:0] TPQ_RESET   = 15'd480;
    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam logic [15:0] SCALE_MIN   = 16'd3;
    localparam logic [23:0] TEMPO_RESET = 24'd500000;
    localparam logic [19:0] US_PER_SEC  = 20'd1000000;
    // Whole samples per tick at the reset tempo and register values.
    localparam logic [63:0] SPT_RESET_INT = 64'd50;

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
        PH_META_LEN, PH_META_SKIP, PH_TEMPO, PH_SYSEX_LEN, PH_SYSEX_SKIP
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [2:0] ev_type;
        logic [3:0] channel;
        logic [6:0] data_a;
        logic [6:0] data_b;
        logic       ended;
    } t_event;

    typedef struct packed {
        logic take;
        logic mul;
        logic sum;
        logic acc;
    } t_ctrl_cmd;

    typedef struct packed {
        logic delta_end;
        logic tempo_end;
        logic cfg_recalc;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/smf_div.sv */
module smf_div #(
    parameter int FRAC_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_tempo_us,
    input  logic [17:0] i_sample_rate,
    input  logic [14:0] i_tpq,
    input  logic [15:0] i_scale,
    output logic        o_busy,
    output logic [63:0] o_spt
);

    localparam int DEN_W = 51;

    typedef enum logic [1:0] {D_IDLE, D_MUL1, D_MUL2, D_RUN} t_dstate;

    t_dstate          r_state;
    logic [41:0]      r_num;
    logic [30:0]      r_sc_tpq;
    logic [DEN_W-1:0] r_den;
    logic [127:0]     r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [63:0]      r_q;
    logic             r_over;
    logic [6:0]       r_cnt;
    logic [63:0]      r_spt;

    logic [15:0]      scale_c;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [63:0]      n_q;
    logic             n_over;

    assign scale_c = (i_scale < smf_pkg::SCALE_MIN) ? smf_pkg::SCALE_MIN : i_scale;
    assign rem_sh  = {r_rem, r_dvd[127]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign n_q     = {r_q[62:0], ge};
    // Quotient bits above bit 63 only flag saturation.
    assign n_over  = r_over | (ge & ~r_cnt[6]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_spt   <= smf_pkg::SPT_RESET_INT << FRAC_BITS;
        end else if (i_start) begin
            r_state <= D_MUL1;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                end
                D_MUL1: begin
                    r_num    <= {18'd0, i_tempo_us} * {24'd0, i_sample_rate};
                    r_sc_tpq <= {15'd0, scale_c} * {16'd0, i_tpq};
                    r_state  <= D_MUL2;
                end
                D_MUL2: begin
                    r_den  <= {20'd0, r_sc_tpq} * {31'd0, smf_pkg::US_PER_SEC};
                    r_dvd  <= 128'(r_num) << (8 + FRAC_BITS);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_over <= 1'b0;
                    r_cnt  <= '0;
                    if (r_sc_tpq == 31'd0) begin
                        r_spt   <= '0;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
                    r_q    <= n_q;
                    r_over <= n_over;
                    r_dvd  <= {r_dvd[126:0], 1'b0};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_spt   <= n_over ? '1 : n_q;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != D_IDLE);
    assign o_spt  = r_spt;

endmodule

/* rtl/smf_ctrl.sv */
module smf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  smf_pkg::t_dp_status   i_status,
    input  logic                  i_div_busy,
    output logic                  o_in_ready,
    output smf_pkg::t_ctrl_cmd    o_cmd,
    output logic                  o_spt_start
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_ACC} t_state;

    t_state r_state;
    logic   take;

    assign o_in_ready = (r_state == S_IDLE) && !i_div_busy && i_status.out_free;
    assign take       = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (take && i_status.delta_end) r_state <= S_MUL;
                S_MUL:  r_state <= S_SUM;
                S_SUM:  r_state <= S_ACC;
                S_ACC:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd.take  = take;
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.sum   = (r_state == S_SUM);
    assign o_cmd.acc   = (r_state == S_ACC);
    assign o_spt_start = (take && i_status.tempo_end) || i_status.cfg_recalc;

endmodule

/* rtl/smf_dpath.sv */
module smf_dpath #(
    parameter int OFFSET_BITS = 48,
    parameter int FRAC_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smf_pkg::t_ctrl_cmd                  i_cmd,
    output smf_pkg::t_dp_status                 o_status,
    input  logic [smf_pkg::IN_TDATA_W-1:0]      i_byte,
    input  logic                                i_op,
    input  logic                                i_last,
    input  logic                                i_cfg_wr_en,
    input  logic [1:0]                          i_cfg_index,
    input  logic [smf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [63:0]                         i_spt,
    output logic [23:0]                         o_tempo_us,
    output logic [17:0]                         o_sample_rate,
    output logic [14:0]                         o_tpq,
    output logic [15:0]                         o_scale,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic [smf_pkg::OUT_TDATA_W-1:0]     o_m_data,
    output logic                                o_m_last
);

    function automatic logic two_data(input logic [7:0] st);
        logic [3:0] hi;
        hi = st[7:4];
        return hi == smf_pkg::HI_NOTE_OFF || hi == smf_pkg::HI_NOTE_ON ||
               hi == smf_pkg::HI_POLY_AT || hi == smf_pkg::HI_CONTROL ||
               hi == smf_pkg::HI_BEND;
    endfunction

    function automatic smf_pkg::t_event chan_ev(input logic [7:0] st,
                                                input logic [7:0] d1,
                                                input logic [7:0] d2);
        smf_pkg::t_event ev;
        ev = '0;
        ev.channel = st[3:0];
        ev.data_a  = d1[6:0];
        unique case (st[7:4])
            smf_pkg::HI_NOTE_OFF: begin
                ev.valid   = 1'b1;
                ev.ev_type = smf_pkg::EV_NOTE_OFF;
            end
            smf_pkg::HI_NOTE_ON: begin
                ev.valid = 1'b1;
                if (d2 == 8'd0) begin
                    ev.ev_type = smf_pkg::EV_NOTE_OFF;
                end else begin
                    ev.ev_type = smf_pkg::EV_NOTE_ON;
                    ev.data_b  = d2[6:0];
                end
            end
            smf_pkg::HI_CONTROL: begin
                ev.valid = 1'b1;
                if (d1 == smf_pkg::B_CC_ALL_OFF || d1 == smf_pkg::B_CC_RESET) begin
                    ev.ev_type = smf_pkg::EV_ALL_OFF;
                    ev.data_a  = '0;
                end else begin
                    ev.ev_type = smf_pkg::EV_CONTROL;
                    ev.data_b  = d2[6:0];
                end
            end
            smf_pkg::HI_PROGRAM: begin
                ev.valid   = 1'b1;
                ev.ev_type = smf_pkg::EV_PROGRAM;
            end
            smf_pkg::HI_BEND: begin
                ev.valid   = 1'b1;
                ev.ev_type = smf_pkg::EV_BEND;
                ev.data_b  = d2[6:0];
            end
            default: ev = '0;
        endcase
        return ev;
    endfunction

    smf_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_run, n_run;
    logic [31:0] r_varlen, n_varlen;
    logic [7:0]  r_kind, n_kind;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_cur, n_cur;
    logic [7:0]  r_first, n_first;
    logic [23:0] r_tcol, n_tcol;
    logic [23:0] r_tempo, n_tempo;
    logic        r_fin, n_fin;
    logic [FRAC_BITS-1:0]   r_frac;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [17:0] r_rate;
    logic [14:0] r_tpq;
    logic [15:0] r_scale;
    logic [47:0] r_start;
    logic [31:0] r_ticks;
    logic [63:0] r_plo, r_phi;
    logic [96:0] r_sum;
    logic        r_ovalid;
    logic [smf_pkg::OUT_TDATA_W-1:0] r_odata;
    logic        r_olast;

    smf_pkg::t_event ev;
    logic        delta_end, tempo_end;
    logic [31:0] vl, left_dec;
    logic [23:0] tc;
    logic [47:0] ev_sample;

    assign vl       = {r_varlen[24:0], i_byte[6:0]};
    assign left_dec = r_left - 32'd1;
    assign tc       = {r_tcol[15:0], i_byte};

    always_comb begin
        n_phase   = r_phase;
        n_run     = r_run;
        n_varlen  = r_varlen;
        n_kind    = r_kind;
        n_left    = r_left;
        n_cur     = r_cur;
        n_first   = r_first;
        n_tcol    = r_tcol;
        n_tempo   = r_tempo;
        n_fin     = r_fin;
        ev        = '0;
        delta_end = 1'b0;
        tempo_end = 1'b0;
        if (i_op == smf_pkg::OP_RESTART) begin
            n_phase  = smf_pkg::PH_DELTA;
            n_run    = '0;
            n_varlen = '0;
            n_kind   = '0;
            n_left   = '0;
            n_cur    = '0;
            n_first  = '0;
            n_tcol   = '0;
            n_fin    = 1'b0;
        end else if (!r_fin) begin
            unique case (r_phase)
                smf_pkg::PH_DELTA: begin
                    n_varlen = vl;
                    if (!i_byte[7]) begin
                        delta_end = 1'b1;
                        n_varlen  = '0;
                        n_phase   = smf_pkg::PH_STATUS;
                    end
                end
                smf_pkg::PH_STATUS: begin
                    if (i_byte == smf_pkg::B_META) begin
                        n_phase = smf_pkg::PH_META_TYPE;
                    end else if (i_byte == smf_pkg::B_SYSEX ||
                                 i_byte == smf_pkg::B_SYSEX_ESC) begin
                        n_varlen = '0;
                        n_phase  = smf_pkg::PH_SYSEX_LEN;
                    end else if (!i_byte[7]) begin
                        if (r_run == 8'd0) begin
                            n_fin = 1'b1;
                        end else begin
                            n_cur   = r_run;
                            n_first = i_byte;
                            if (two_data(r_run)) begin
                                n_phase = smf_pkg::PH_DATA2;
                            end else begin
                                n_phase  = smf_pkg::PH_DELTA;
                                n_varlen = '0;
                                ev       = chan_ev(r_run, i_byte, 8'd0);
                            end
                        end
                    end else begin
                        n_run   = i_byte;
                        n_cur   = i_byte;
                        n_phase = smf_pkg::PH_DATA1;
                    end
                end
                smf_pkg::PH_DATA1: begin
                    n_first = i_byte;
                    if (two_data(r_cur)) begin
                        n_phase = smf_pkg::PH_DATA2;
                    end else begin
                        n_phase  = smf_pkg::PH_DELTA;
                        n_varlen = '0;
                        ev       = chan_ev(r_cur, i_byte, 8'd0);
                    end
                end
                smf_pkg::PH_DATA2: begin
                    n_phase  = smf_pkg::PH_DELTA;
                    n_varlen = '0;
                    ev       = chan_ev(r_cur, r_first, i_byte);
                end
                smf_pkg::PH_META_TYPE: begin
                    n_kind   = i_byte;
                    n_varlen = '0;
                    n_phase  = smf_pkg::PH_META_LEN;
                end
                smf_pkg::PH_META_LEN: begin
                    n_varlen = vl;
                    if (!i_byte[7]) begin
                        n_varlen = '0;
                        if (r_kind == smf_pkg::B_META_TEMPO && vl == 32'd3) begin
                            n_tcol  = '0;
                            n_left  = 32'd3;
                            n_phase = smf_pkg::PH_TEMPO;
                        end else if (vl == 32'd0) begin
                            n_phase = smf_pkg::PH_DELTA;
                            if (r_kind == smf_pkg::B_META_EOT) begin
                                n_fin      = 1'b1;
                                ev.valid   = 1'b1;
                                ev.ev_type = smf_pkg::EV_ALL_OFF;
                                ev.ended   = 1'b1;
                            end
                        end else begin
                            n_left  = vl;
                            n_phase = smf_pkg::PH_META_SKIP;
                        end
                    end
                end
                smf_pkg::PH_META_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_phase  = smf_pkg::PH_DELTA;
                        n_varlen = '0;
                        if (r_kind == smf_pkg::B_META_EOT) begin
                            n_fin      = 1'b1;
                            ev.valid   = 1'b1;
                            ev.ev_type = smf_pkg::EV_ALL_OFF;
                            ev.ended   = 1'b1;
                        end
                    end
                end
                smf_pkg::PH_TEMPO: begin
                    // The tempo meta kind does not end the track; a byte with tlast still does.
                    n_tcol = tc;
                    n_left = left_dec;
                    if (left_dec == 32'd0) begin
                        n_tempo   = tc;
                        tempo_end = 1'b1;
                        n_phase   = smf_pkg::PH_DELTA;
                        n_varlen  = '0;
                    end
                end
                smf_pkg::PH_SYSEX_LEN: begin
                    n_varlen = vl;
                    if (!i_byte[7]) begin
                        n_left   = vl;
                        n_varlen = '0;
                        n_phase  = (vl == 32'd0) ? smf_pkg::PH_DELTA : smf_pkg::PH_SYSEX_SKIP;
                    end
                end
                smf_pkg::PH_SYSEX_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 32'd0) n_phase = smf_pkg::PH_DELTA;
                end
                default: begin
                    n_phase  = smf_pkg::PH_DELTA;
                    n_varlen = '0;
                end
            endcase
            if (i_last) n_fin = 1'b1;
        end
    end

    assign ev_sample = 48'(64'(r_start) + 64'(r_offset));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= smf_pkg::PH_DELTA;
            r_run    <= '0;
            r_varlen <= '0;
            r_kind   <= '0;
            r_left   <= '0;
            r_cur    <= '0;
            r_first  <= '0;
            r_tcol   <= '0;
            r_tempo  <= smf_pkg::TEMPO_RESET;
            r_fin    <= 1'b0;
            r_frac   <= '0;
            r_offset <= '0;
            r_rate   <= smf_pkg::RATE_RESET;
            r_tpq    <= smf_pkg::TPQ_RESET;
            r_scale  <= smf_pkg::SCALE_RESET;
            r_start  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    smf_pkg::CFG_SAMPLE_RATE: r_rate  <= i_cfg_wdata[17:0];
                    smf_pkg::CFG_TICKS_PER_Q: r_tpq   <= i_cfg_wdata[14:0];
                    smf_pkg::CFG_TEMPO_SCALE: r_scale <= i_cfg_wdata[15:0];
                    smf_pkg::CFG_START_SMP:   r_start <= i_cfg_wdata[47:0];
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                r_phase  <= n_phase;
                r_run    <= n_run;
                r_varlen <= n_varlen;
                r_kind   <= n_kind;
                r_left   <= n_left;
                r_cur    <= n_cur;
                r_first  <= n_first;
                r_tcol   <= n_tcol;
                r_tempo  <= n_tempo;
                r_fin    <= n_fin;
                if (i_op == smf_pkg::OP_RESTART) begin
                    r_frac   <= '0;
                    r_offset <= '0;
                end
            end
            if (i_cmd.acc) begin
                r_frac   <= r_sum[FRAC_BITS-1:0];
                r_offset <= r_offset + r_sum[FRAC_BITS +: OFFSET_BITS];
            end
            if (i_cmd.take && ev.valid) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && delta_end) r_ticks <= vl;
        if (i_cmd.mul) begin
            r_plo <= {32'd0, r_ticks} * {32'd0, i_spt[31:0]};
            r_phi <= {32'd0, r_ticks} * {32'd0, i_spt[63:32]};
        end
        if (i_cmd.sum) begin
            r_sum <= {33'd0, r_plo} + {1'b0, r_phi, 32'd0} + 97'(r_frac);
        end
        if (i_cmd.take && ev.valid) begin
            r_odata <= {3'd0, ev_sample, ev.data_b, ev.data_a, ev.channel, ev.ev_type};
            r_olast <= ev.ended;
        end
    end

    assign o_status.delta_end  = delta_end;
    assign o_status.tempo_end  = tempo_end;
    assign o_status.cfg_recalc = i_cfg_wr_en && (i_cfg_index != smf_pkg::CFG_START_SMP);
    assign o_status.out_free   = !r_ovalid || i_m_ready;

    assign o_tempo_us    = r_tempo;
    assign o_sample_rate = r_rate;
    assign o_tpq         = r_tpq;
    assign o_scale       = r_scale;
    assign o_m_valid     = r_ovalid;
    assign o_m_data      = r_odata;
    assign o_m_last      = r_olast;

endmodule

/* rtl/smf_track_event_parser.sv */
// Channel   | Dir | tdata (low bit up)                                   | tuser | tlast
// s_axis    | in  | data_byte[7:0]                                       | op    | last_of_track
// m_axis    | out | event_type, channel, data_a, data_b, event_sample, 0 | -     | track_ended
// cfg       | in  | wr_en, index 0..3, wdata[47:0]                       | -     | -
//
// The last byte of a delta time stalls input while its 32-bit tick count is multiplied by
// samples-per-tick in two 32x32 halves, summed, then accumulated. A tempo meta event or a
// write of the sample-rate, ticks-per-quarter or tempo-scale register runs the bit-serial
// divider, which holds tready low while busy. Reset is synchronous; there is no clearing
// pass. A result waits in the output register while the next byte is taken, unless it stalls.
`include "smf_track_event_parser_macros.svh"

module smf_track_event_parser #(
    parameter int OFFSET_BITS = 48,
    parameter int FRAC_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [smf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // data_byte
    input  logic                               i_s_axis_tuser,  // op
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // event_type[2:0], channel[6:3], data_a[13:7], data_b[20:14], event_sample[68:21]
    output logic [smf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_wr_en,
    input  logic [1:0]                         i_cfg_index,
    input  logic [smf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    smf_pkg::t_ctrl_cmd  w_cmd;
    smf_pkg::t_dp_status w_dp_st;
    logic        w_div_busy;
    logic        w_spt_start;
    logic [63:0] w_spt;
    logic [23:0] w_tempo;
    logic [17:0] w_rate;
    logic [14:0] w_tpq;
    logic [15:0] w_scale;
    logic        w_out_is_eot;

    smf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_status    (w_dp_st),
        .i_div_busy  (w_div_busy),
        .o_in_ready  (o_s_axis_tready),
        .o_cmd       (w_cmd),
        .o_spt_start (w_spt_start)
    );

    smf_dpath #(
        .OFFSET_BITS (OFFSET_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_dp_st),
        .i_byte        (i_s_axis_tdata),
        .i_op          (i_s_axis_tuser),
        .i_last        (i_s_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_spt         (w_spt),
        .o_tempo_us    (w_tempo),
        .o_sample_rate (w_rate),
        .o_tpq         (w_tpq),
        .o_scale       (w_scale),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_m_data      (o_m_axis_tdata),
        .o_m_last      (o_m_axis_tlast)
    );

    smf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_spt_start),
        .i_tempo_us    (w_tempo),
        .i_sample_rate (w_rate),
        .i_tpq         (w_tpq),
        .i_scale       (w_scale),
        .o_busy        (w_div_busy),
        .o_spt         (w_spt)
    );

    assign w_out_is_eot = (o_m_axis_tdata[2:0] == smf_pkg::EV_ALL_OFF) &&
                          (o_m_axis_tdata[6:3] == 4'd0);

    `SMF_ASSERT_NXT(a_delta_stall, w_cmd.take && w_dp_st.delta_end, !o_s_axis_tready)
    `SMF_ASSERT_IMP(a_div_stall, w_div_busy, !o_s_axis_tready)
    `SMF_ASSERT_IMP(a_end_all_off, o_m_axis_tvalid && o_m_axis_tlast, w_out_is_eot)

endmodule
